[src/psslm_pkg.sv]
// ----------------------------------------------------------------------------
// psslm_pkg: shared types and constants of the sequence loss monitor
// Request layouts, opcodes, rate units and the constant-divider coefficients.
// ----------------------------------------------------------------------------
package psslm_pkg;

  localparam int SOURCES_DEFAULT  = 256;
  localparam int SEQ_BITS_DEFAULT = 16;

  localparam logic [7:0] HEADER_LENGTH_RESET = 8'd16;

  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_SEND    = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  localparam logic [1:0] UNIT_BPS  = 2'd0;
  localparam logic [1:0] UNIT_KBPS = 2'd1;
  localparam logic [1:0] UNIT_MBPS = 2'd2;

  localparam logic [31:0] CNT_MAX        = 32'hFFFF_FFFF;
  localparam logic [31:0] KBPS_THRESHOLD = 32'd1250;
  localparam logic [31:0] MBPS_THRESHOLD = 32'd1250000;
  localparam logic [15:0] BPS_RATE_MAX   = 16'd10000;

  // Rate in kbps is bytes / 125, taken as (bytes * KBPS_RECIP) >> KBPS_SHIFT.
  localparam logic [21:0] KBPS_RECIP = 22'd2147484;
  localparam int          KBPS_SHIFT = 28;
  // Rate in mbps is (bytes / 8) / 15625, taken as (x * MBPS_RECIP) >> MBPS_SHIFT.
  localparam logic [29:0] MBPS_RECIP = 30'd562949954;
  localparam int          MBPS_SHIFT = 43;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  source_id;
    logic [15:0] sequence_req;
    logic [15:0] length;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] packet_lost;
    logic        report_active;
    logic [31:0] period_sent;
    logic [31:0] period_received;
    logic [31:0] period_lost;
    logic [15:0] send_rate;
    logic [1:0]  send_unit;
    logic [15:0] receive_rate;
    logic [1:0]  receive_unit;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  unit;
    logic [15:0] value;
  } rate_t;

endpackage

[src/per_source_sequence_loss_monitor_unit.sv]
// ----------------------------------------------------------------------------
// per_source_sequence_loss_monitor_unit: packet loss monitor
// Counts sent and received traffic and tracks per-source sequence gaps.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_data  (psslm_pkg::in_item_t)
// out      output     out_valid / out_ready out_data (psslm_pkg::out_item_t)
// cfg      input      cfg_write             cfg_data (header length)
//
// One request is accepted every cycle while in_ready is high; it is held in
// the request stage and its result is then registered into out_data.
// The expected-sequence memory is read at acceptance and written as the
// request moves into the result register, with a bypass for back-to-back
// requests from the same source.
// Reset invalidates all table entries at once; there is no clearing pass.
// While the result register is stalled, the request stage holds, and in_ready
// falls once that stage is full.
// ----------------------------------------------------------------------------
module per_source_sequence_loss_monitor_unit #(
  parameter int SOURCES  = psslm_pkg::SOURCES_DEFAULT,
  parameter int SEQ_BITS = psslm_pkg::SEQ_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  psslm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output psslm_pkg::out_item_t out_data,
  input  logic                 cfg_write,
  input  logic [7:0]           cfg_data
);

  localparam int IDX_W = $clog2(SOURCES);

  logic [7:0]          header_length;
  logic                s1_valid;
  psslm_pkg::in_item_t s1;
  logic [SEQ_BITS-1:0] rd_data;
  logic                fwd_hit;
  logic [SEQ_BITS-1:0] fwd_val;
  logic [SOURCES-1:0]  seq_valid;
  logic [SEQ_BITS-1:0] seq_mem [SOURCES];

  logic [31:0] sent_packets;
  logic [31:0] received_packets;
  logic [31:0] lost_packets;
  logic [31:0] sent_bytes;
  logic [31:0] received_bytes;

  logic [31:0] sent_packets_next;
  logic [31:0] received_packets_next;
  logic [31:0] lost_packets_next;
  logic [31:0] sent_bytes_next;
  logic [31:0] received_bytes_next;

  logic                 in_accept;
  logic                 s1_fire;
  logic [IDX_W-1:0]     in_idx;
  logic [IDX_W-1:0]     s1_idx;
  logic [47:0]          seq_wide;
  logic [SEQ_BITS-1:0]  seq;
  logic [SEQ_BITS-1:0]  expected;
  logic [SEQ_BITS-1:0]  gap;
  logic [SEQ_BITS-1:0]  expected_next;
  logic [47:0]          gap_wide;
  logic                 rx_ok;
  logic                 mem_we;
  psslm_pkg::rate_t     send_rate_calc;
  psslm_pkg::rate_t     receive_rate_calc;
  psslm_pkg::out_item_t out_next;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? psslm_pkg::CNT_MAX : sum[31:0];
  endfunction

  function automatic psslm_pkg::rate_t rate_calc(input logic [31:0] bytes);
    logic [43:0]      pk;
    logic [58:0]      pm;
    psslm_pkg::rate_t r;
    pk = 44'(bytes[20:0]) * 44'(psslm_pkg::KBPS_RECIP);
    pm = 59'(bytes[31:3]) * 59'(psslm_pkg::MBPS_RECIP);
    if (bytes > psslm_pkg::MBPS_THRESHOLD) begin
      r.unit  = psslm_pkg::UNIT_MBPS;
      r.value = pm[psslm_pkg::MBPS_SHIFT +: 16];
    end else if (bytes > psslm_pkg::KBPS_THRESHOLD) begin
      r.unit  = psslm_pkg::UNIT_KBPS;
      r.value = pk[psslm_pkg::KBPS_SHIFT +: 16];
    end else begin
      r.unit  = psslm_pkg::UNIT_BPS;
      r.value = {bytes[12:0], 3'b000};
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] slot_of(input logic [7:0] id);
    logic [IDX_W-1:0] slot;
    slot = '0;
    for (int i = 0; i < 256; i++) begin
      if (id == 8'(i)) begin
        slot = IDX_W'(i % SOURCES);
      end
    end
    return slot;
  endfunction

  assign s1_fire   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;
  assign in_accept = in_valid && in_ready;
  assign in_idx    = slot_of(in_data.source_id);
  assign s1_idx    = slot_of(s1.source_id);

  always_comb begin
    seq_wide          = {32'd0, s1.sequence_req};
    seq               = seq_wide[SEQ_BITS-1:0];
    rx_ok             = (s1.operation == psslm_pkg::OP_RECEIVE) &&
                        (s1.length > 16'(header_length));
    mem_we            = s1_fire && rx_ok;
    if (!seq_valid[s1_idx]) begin
      expected = seq;
    end else if (fwd_hit) begin
      expected = fwd_val;
    end else begin
      expected = rd_data;
    end
    gap               = seq - expected;
    expected_next     = seq + SEQ_BITS'(1);
    gap_wide          = 48'(gap);
    send_rate_calc    = rate_calc(sent_bytes);
    receive_rate_calc = rate_calc(received_bytes);
  end

  always_comb begin
    sent_packets_next     = sent_packets;
    received_packets_next = received_packets;
    lost_packets_next     = lost_packets;
    sent_bytes_next       = sent_bytes;
    received_bytes_next   = received_bytes;
    out_next              = '0;
    case (s1.operation)
      psslm_pkg::OP_RECEIVE: begin
        if (rx_ok) begin
          received_packets_next = sat_add(received_packets, 32'd1);
          received_bytes_next   = sat_add(received_bytes, 32'(s1.length));
          lost_packets_next     = sat_add(lost_packets, gap_wide[31:0]);
          out_next.packet_lost  = gap_wide[15:0];
        end else begin
          out_next.status = psslm_pkg::STATUS_SHORT;
        end
      end
      psslm_pkg::OP_SEND: begin
        sent_packets_next = sat_add(sent_packets, 32'd1);
        sent_bytes_next   = sat_add(sent_bytes, 32'(s1.length));
      end
      psslm_pkg::OP_TICK: begin
        out_next.report_active   = (sent_packets != '0) || (received_packets != '0) ||
                                   (lost_packets != '0);
        out_next.period_sent     = sent_packets;
        out_next.period_received = received_packets;
        out_next.period_lost     = lost_packets;
        out_next.send_rate       = send_rate_calc.value;
        out_next.send_unit       = send_rate_calc.unit;
        out_next.receive_rate    = receive_rate_calc.value;
        out_next.receive_unit    = receive_rate_calc.unit;
        sent_packets_next        = '0;
        received_packets_next    = '0;
        lost_packets_next        = '0;
        sent_bytes_next          = '0;
        received_bytes_next      = '0;
      end
      default: begin
        sent_packets_next     = '0;
        received_packets_next = '0;
        lost_packets_next     = '0;
        sent_bytes_next       = '0;
        received_bytes_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_length    <= psslm_pkg::HEADER_LENGTH_RESET;
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      fwd_hit          <= 1'b0;
      seq_valid        <= '0;
      sent_packets     <= '0;
      received_packets <= '0;
      lost_packets     <= '0;
      sent_bytes       <= '0;
      received_bytes   <= '0;
    end else begin
      if (cfg_write) begin
        header_length <= cfg_data;
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= mem_we && (s1_idx == in_idx);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_fire) begin
        sent_packets     <= sent_packets_next;
        received_packets <= received_packets_next;
        lost_packets     <= lost_packets_next;
        sent_bytes       <= sent_bytes_next;
        received_bytes   <= received_bytes_next;
        if (s1.operation == psslm_pkg::OP_CLEAR) begin
          seq_valid <= '0;
        end else if (rx_ok) begin
          seq_valid[s1_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1      <= in_data;
      fwd_val <= expected_next;
    end
    if (s1_fire) begin
      out_data <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seq_mem[s1_idx] <= expected_next;
    end
    if (in_accept) begin
      rd_data <= seq_mem[in_idx];
    end
  end

endmodule

[src/psslm_checker.sv]
// ----------------------------------------------------------------------------
// psslm_checker: port-level checks of the sequence loss monitor
// Watches the result channel for handshake and field consistency.
// ----------------------------------------------------------------------------
module psslm_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input psslm_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed while stalled.");

  a_short_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |->
      out_data.packet_lost == '0 && !out_data.report_active &&
      out_data.period_received == '0 && out_data.receive_rate == '0)
    else $error("Rejected request carries report or loss data.");

  a_idle_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.report_active |->
      out_data.period_sent == '0 && out_data.period_received == '0 &&
      out_data.period_lost == '0)
    else $error("Period counts without activity flag.");

  a_bps_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.send_unit == psslm_pkg::UNIT_BPS |->
      out_data.send_rate <= psslm_pkg::BPS_RATE_MAX)
    else $error("Send rate too large for bps unit.");

endmodule

bind per_source_sequence_loss_monitor_unit psslm_checker u_psslm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[dv/psslm_loss_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psslm_loss_checker: result predictor and scoreboard for the loss monitor
// Watches the request, result and header-length ports of the monitor, keeps
// its own copy of the per-source sequence table and the traffic counters,
// predicts one result per accepted request and compares every accepted result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module psslm_loss_checker
  import psslm_pkg::*;
#(
  parameter int SOURCES = SOURCES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  output int         failures,
  output int         pending,
  output int         checked,
  output int         ticks_seen,
  output int         short_seen
);

  localparam logic [63:0] KILO = 64'd1000;
  localparam logic [63:0] MEGA = 64'd1000000;

  logic [7:0]  hdr_len;
  logic        seq_known [SOURCES];
  logic [15:0] next_seq [SOURCES];
  logic [31:0] tx_pkts;
  logic [31:0] rx_pkts;
  logic [31:0] lost_pkts;
  logic [31:0] tx_bytes;
  logic [31:0] rx_bytes;

  out_item_t expected_results [$];

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? CNT_MAX : sum[31:0];
  endfunction

  function automatic rate_t rate_for(logic [31:0] bytes);
    rate_t       r;
    logic [63:0] bits;
    bits = {32'd0, bytes} * 64'd8;
    if (bytes > MBPS_THRESHOLD) begin
      r.unit = UNIT_MBPS;
      bits = bits / MEGA;
    end else if (bytes > KBPS_THRESHOLD) begin
      r.unit = UNIT_KBPS;
      bits = bits / KILO;
    end else begin
      r.unit = UNIT_BPS;
    end
    r.value = (bits > 64'hFFFF) ? 16'hFFFF : bits[15:0];
    return r;
  endfunction

  function automatic void clear_counts();
    tx_pkts = '0;
    rx_pkts = '0;
    lost_pkts = '0;
    tx_bytes = '0;
    rx_bytes = '0;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < SOURCES; i++) begin
      seq_known[i] = 1'b0;
      next_seq[i] = '0;
    end
  endfunction

  function automatic out_item_t predict(in_item_t req);
    out_item_t   res;
    logic [15:0] gap;
    rate_t       r;
    int          slot;
    res = '0;
    slot = int'(req.source_id) % SOURCES;
    case (req.operation)
      OP_RECEIVE: begin
        if (req.length <= {8'd0, hdr_len}) begin
          res.status = STATUS_SHORT;
          short_seen++;
        end else begin
          rx_pkts = sat_add(rx_pkts, 32'd1);
          rx_bytes = sat_add(rx_bytes, {16'd0, req.length});
          if (!seq_known[slot]) begin
            seq_known[slot] = 1'b1;
            next_seq[slot] = req.sequence_req;
          end
          gap = req.sequence_req - next_seq[slot];
          next_seq[slot] = req.sequence_req + 16'd1;
          lost_pkts = sat_add(lost_pkts, {16'd0, gap});
          res.packet_lost = gap;
        end
      end
      OP_SEND: begin
        tx_pkts = sat_add(tx_pkts, 32'd1);
        tx_bytes = sat_add(tx_bytes, {16'd0, req.length});
      end
      OP_TICK: begin
        res.report_active = (tx_pkts != 0) || (rx_pkts != 0) || (lost_pkts != 0);
        res.period_sent = tx_pkts;
        res.period_received = rx_pkts;
        res.period_lost = lost_pkts;
        r = rate_for(tx_bytes);
        res.send_rate = r.value;
        res.send_unit = r.unit;
        r = rate_for(rx_bytes);
        res.receive_rate = r.value;
        res.receive_unit = r.unit;
        clear_counts();
        ticks_seen++;
      end
      default: begin
        clear_counts();
        clear_table();
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v,
                             inout bit bad);
    if (got_v !== want_v) begin
      bad = 1'b1;
      if (failures < 10)
        $display("Mismatch in result %0d, %s: expected %0h, actual %0h",
                 checked, name, want_v, got_v);
    end
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    bit        bad;
    if (expected_results.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("Result arrived with no request waiting for it: %h", got);
      return;
    end
    want = expected_results.pop_front();
    checked++;
    bad = 1'b0;
    check_field("status", 32'(want.status), 32'(got.status), bad);
    check_field("packet_lost", 32'(want.packet_lost), 32'(got.packet_lost), bad);
    check_field("report_active", 32'(want.report_active), 32'(got.report_active), bad);
    check_field("period_sent", want.period_sent, got.period_sent, bad);
    check_field("period_received", want.period_received, got.period_received, bad);
    check_field("period_lost", want.period_lost, got.period_lost, bad);
    check_field("send_rate", 32'(want.send_rate), 32'(got.send_rate), bad);
    check_field("send_unit", 32'(want.send_unit), 32'(got.send_unit), bad);
    check_field("receive_rate", 32'(want.receive_rate), 32'(got.receive_rate), bad);
    check_field("receive_unit", 32'(want.receive_unit), 32'(got.receive_unit), bad);
    if (bad)
      failures++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hdr_len = HEADER_LENGTH_RESET;
      clear_counts();
      clear_table();
      expected_results.delete();
      failures = 0;
      checked = 0;
      ticks_seen = 0;
      short_seen = 0;
    end else begin
      if (out_valid && out_ready)
        compare_result(out_data);
      if (cfg_write)
        hdr_len = cfg_data;
      if (in_valid && in_ready)
        expected_results.push_back(predict(in_data));
    end
    pending = expected_results.size();
  end

endmodule

[dv/per_source_sequence_loss_monitor_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_source_sequence_loss_monitor_unit_tb: top-level bench for the monitor
// Drives receive, send, tick and clear requests with random gaps and random
// result back-pressure, including a run of large sequence gaps and phases with
// different header lengths, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module per_source_sequence_loss_monitor_unit_tb;
  import psslm_pkg::*;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = '0;

  int failures;
  int pending;
  int checked;
  int ticks_seen;
  int short_seen;

  bit          idle_on = 1'b1;
  int          requests = 0;
  int          settings_used = 1;
  logic [7:0]  hot_base = '0;
  logic [15:0] seq_track [256];

  per_source_sequence_loss_monitor_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  psslm_loss_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .failures   (failures),
    .pending    (pending),
    .checked    (checked),
    .ticks_seen (ticks_seen),
    .short_seen (short_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Timeout with %0d results still outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = idle_on ? $urandom_range(0, 19) : 0;
      @(negedge clk);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic issue(in_item_t req);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (!in_ready);
    requests++;
  endtask

  task automatic issue_req(logic [1:0] op, logic [7:0] src, logic [15:0] seq,
                           logic [15:0] len);
    in_item_t req;
    req.operation = op;
    req.source_id = src;
    req.sequence_req = seq;
    req.length = len;
    issue(req);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_header(logic [7:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    settings_used++;
  endtask

  function automatic in_item_t random_request(logic [7:0] hdr);
    in_item_t req;
    int       roll;
    req.operation = OP_RECEIVE;
    req.source_id = 8'($urandom_range(0, 255));
    req.sequence_req = 16'($urandom_range(0, 65535));
    req.length = 16'($urandom_range(0, 65535));
    roll = $urandom_range(0, 99);
    if (roll >= 97)
      req.operation = OP_CLEAR;
    else if (roll >= 87)
      req.operation = OP_TICK;
    else if (roll >= 60)
      req.operation = OP_SEND;
    roll = $urandom_range(0, 99);
    if (roll < 25)
      req.length = 16'($urandom_range(0, int'(hdr) + 2));
    else if (roll < 35)
      req.length = 16'hFFFF - 16'($urandom_range(0, 3));
    if (req.operation == OP_RECEIVE) begin
      if ($urandom_range(0, 4) != 0)
        req.source_id = hot_base + 8'($urandom_range(0, 5));
      roll = $urandom_range(0, 99);
      if (roll < 70)
        req.sequence_req = seq_track[req.source_id];
      else if (roll < 85)
        req.sequence_req = seq_track[req.source_id] + 16'($urandom_range(1, 5));
      else if (roll < 90)
        req.sequence_req = seq_track[req.source_id] - 16'd1;
      seq_track[req.source_id] = req.sequence_req + 16'd1;
    end
    return req;
  endfunction

  initial begin
    logic [7:0] hdr;
    for (int i = 0; i < 256; i++)
      seq_track[i] = 16'($urandom_range(0, 65535));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests at the reset header length.
    issue_req(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    issue_req(OP_RECEIVE, 8'd3, 16'd50, 16'd0);
    issue_req(OP_RECEIVE, 8'd3, 16'd50, 16'd16);
    issue_req(OP_RECEIVE, 8'd0, 16'd100, 16'd17);
    issue_req(OP_RECEIVE, 8'd0, 16'd101, 16'hFFFF);
    issue_req(OP_RECEIVE, 8'd0, 16'd110, 16'd64);
    issue_req(OP_RECEIVE, 8'd0, 16'd5, 16'd64);
    issue_req(OP_RECEIVE, 8'hFF, 16'hFFFF, 16'd1000);
    issue_req(OP_RECEIVE, 8'hFF, 16'h0000, 16'd1000);
    issue_req(OP_RECEIVE, 8'hFF, 16'hFFFF, 16'd1000);
    issue_req(OP_SEND, 8'hAA, 16'h5555, 16'd0);
    issue_req(OP_SEND, 8'h55, 16'hAAAA, 16'd1250);
    issue_req(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF);
    issue_req(OP_SEND, 8'h00, 16'h0000, 16'd1251);
    issue_req(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    issue_req(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    issue_req(OP_SEND, 8'h12, 16'h3456, 16'd700);
    issue_req(OP_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF);
    issue_req(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    issue_req(OP_RECEIVE, 8'd0, 16'd7, 16'd100);
    issue_req(OP_RECEIVE, 8'd0, 16'd8, 16'd100);
    issue_req(OP_CLEAR, 8'h00, 16'h0000, 16'h0000);
    issue_req(OP_RECEIVE, 8'd0, 16'd300, 16'd100);
    issue_req(OP_TICK, 8'h00, 16'h0000, 16'h0000);

    // Repeating one sequence number loses almost a full window each time,
    // which builds large loss and byte totals back to back.
    drain();
    write_header(8'd200);
    idle_on = 1'b0;
    issue_req(OP_CLEAR, 8'h00, 16'h0000, 16'h0000);
    repeat (16) begin
      issue_req(OP_RECEIVE, 8'd9, 16'h1234, 16'hFFFF);
      issue_req(OP_SEND, 8'd9, 16'h1234, 16'hFFFF);
    end
    issue_req(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    issue_req(OP_TICK, 8'h00, 16'h0000, 16'h0000);

    for (int p = 0; p < 6; p++) begin
      drain();
      if (p == 0)
        hdr = 8'd0;
      else if (p == 1)
        hdr = 8'd255;
      else
        hdr = 8'($urandom_range(0, 255));
      write_header(hdr);
      idle_on = (p == 0) || ($urandom_range(0, 3) != 0);
      hot_base = 8'($urandom_range(0, 255));
      repeat (65) issue(random_request(hdr));
    end

    drain();
    repeat (10) @(negedge clk);
    $display("Ran %0d requests under %0d header lengths; %0d results checked.",
             requests, settings_used, checked);
    $display("The run included %0d ticks and %0d receives rejected as too short.",
             ticks_seen, short_seen);
    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
